// ===== hdl/ps2fr_pkg.sv =====
// Package for the PS/2 frame receiver and packet assembler.
// Holds the item struct types and the frame and slot constants.
// No dependencies.
package ps2fr_pkg;

   // One line sample per input item
   typedef struct packed {
      logic clk_line;
      logic data_line;
   } req_type;

   // One completed frame per result item
   typedef struct packed {
      logic [7:0] received_byte;
      logic       parity_bit;
      logic       packet_ready;
      logic [7:0] packet_first;
      logic [7:0] packet_second;
      logic [7:0] packet_third;
   } rsp_type;

   // Frame edge counts
   localparam logic [3:0] START_EDGE     = 4'd0;
   localparam logic [3:0] LAST_DATA_EDGE = 4'd8;
   localparam logic [3:0] PARITY_EDGE    = 4'd9;
   localparam logic [3:0] FRAME_EDGES    = 4'd11;

   // Packet slot codes
   localparam logic [1:0] SLOT_FIRST  = 2'd0;
   localparam logic [1:0] SLOT_SECOND = 2'd1;
   localparam logic [1:0] SLOT_THIRD  = 2'd2;
   localparam logic [1:0] SLOT_SKIP   = 2'd3;

endpackage

// ===== hdl/ps2_frame_receiver_packet_assembler.sv =====
// PS/2 frame receiver with three-byte movement packet assembler, top level.
// Depends on ps2fr_pkg for the item types and constants.
//
// A result item enters the output register in the cycle after its frame's last
// sample is accepted. Throughput: one line sample per cycle unless a frame's
// last sample waits on a full output register; frame decode is a single pass of
// logic from the accepted sample and the frame state into the output register.
// Reset (synchronous, active high): clock line taken as high, edge counter and
// shift byte cleared, slot counter set to skip the first collected byte,
// reporting disabled, output register empty.
module ps2_frame_receiver_packet_assembler (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  ps2fr_pkg::req_type  req_payload,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output ps2fr_pkg::rsp_type  rsp_payload,
   input  logic                csr_write_enable,
   input  logic                csr_write_data
);

   // Configuration
   logic reporting_enable_ff;

   // Frame state
   logic       clock_previous_ff, clock_previous_in;
   logic [3:0] edge_count_ff,     edge_count_in;
   logic [7:0] shift_byte_ff,     shift_byte_in;
   logic       parity_held_ff,    parity_held_in;

   // Packet state; held bytes need no reset, a packet is only built after
   // both slots were written
   logic [1:0] slot_index_ff,     slot_index_in;
   logic [7:0] held_first_ff,     held_first_in;
   logic [7:0] held_second_ff,    held_second_in;

   // Output register
   logic               rsp_valid_ff, rsp_valid_in;
   ps2fr_pkg::rsp_type rsp_payload_ff, rsp_payload_in;

   logic       accept;
   logic       falling;
   logic       rising;
   logic       emit;
   logic [2:0] bit_idx;
   ps2fr_pkg::rsp_type result;

   // Edge detect against the previous sample
   assign falling = clock_previous_ff & ~req_payload.clk_line;
   assign rising  = ~clock_previous_ff & req_payload.clk_line;
   // Frame completes on the rising edge after the eleventh falling edge
   assign emit    = rising & (edge_count_ff == ps2fr_pkg::FRAME_EDGES);

   // Take a sample whenever it produces no result, or the output register
   // is free or being drained this cycle
   assign req_ready = ~emit | ~rsp_valid_ff | rsp_ready;
   assign accept    = req_valid & req_ready;

   // Data bits arrive LSB first on edges one through eight
   assign bit_idx = 3'(edge_count_ff - 4'd1);

   always_comb begin
      clock_previous_in = clock_previous_ff;
      edge_count_in     = edge_count_ff;
      shift_byte_in     = shift_byte_ff;
      parity_held_in    = parity_held_ff;
      slot_index_in     = slot_index_ff;
      held_first_in     = held_first_ff;
      held_second_in    = held_second_ff;

      result               = '0;
      result.received_byte = shift_byte_ff;
      result.parity_bit    = parity_held_ff;

      if (accept) begin
         clock_previous_in = req_payload.clk_line;
         if (falling) begin
            if (edge_count_ff >= ps2fr_pkg::FRAME_EDGES) begin
               // Out-of-range count: drop the frame
               edge_count_in = '0;
            end else begin
               if (edge_count_ff == ps2fr_pkg::START_EDGE) begin
                  shift_byte_in = '0;
               end else if (edge_count_ff <= ps2fr_pkg::LAST_DATA_EDGE) begin
                  shift_byte_in = shift_byte_ff | (8'(req_payload.data_line) << bit_idx);
               end else if (edge_count_ff == ps2fr_pkg::PARITY_EDGE) begin
                  parity_held_in = req_payload.data_line;
               end
               edge_count_in = edge_count_ff + 4'd1;
            end
         end else if (rising && edge_count_ff >= ps2fr_pkg::FRAME_EDGES) begin
            edge_count_in = '0;
            if (emit && reporting_enable_ff) begin
               case (slot_index_ff)
                  ps2fr_pkg::SLOT_FIRST: begin
                     held_first_in = shift_byte_ff;
                     slot_index_in = ps2fr_pkg::SLOT_SECOND;
                  end
                  ps2fr_pkg::SLOT_SECOND: begin
                     held_second_in = shift_byte_ff;
                     slot_index_in  = ps2fr_pkg::SLOT_THIRD;
                  end
                  ps2fr_pkg::SLOT_THIRD: begin
                     result.packet_ready  = 1'b1;
                     result.packet_first  = held_first_ff;
                     result.packet_second = held_second_ff;
                     result.packet_third  = shift_byte_ff;
                     slot_index_in        = ps2fr_pkg::SLOT_FIRST;
                  end
                  default: begin
                     // Skip slot: discard this byte
                     slot_index_in = ps2fr_pkg::SLOT_FIRST;
                  end
               endcase
            end
         end
      end
   end

   // Output register: load on a completed frame, drop when taken
   always_comb begin
      rsp_valid_in   = rsp_valid_ff & ~rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      if (accept && emit) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reporting_enable_ff <= 1'b0;
         clock_previous_ff   <= 1'b1;
         edge_count_ff       <= '0;
         shift_byte_ff       <= '0;
         parity_held_ff      <= 1'b0;
         slot_index_ff       <= ps2fr_pkg::SLOT_SKIP;
         rsp_valid_ff        <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            reporting_enable_ff <= csr_write_data;
         end
         clock_previous_ff <= clock_previous_in;
         edge_count_ff     <= edge_count_in;
         shift_byte_ff     <= shift_byte_in;
         parity_held_ff    <= parity_held_in;
         slot_index_ff     <= slot_index_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      held_first_ff  <= held_first_in;
      held_second_ff <= held_second_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // A completed frame always lands in the output register and rearms the counter
   assert property (@(posedge clock) disable iff (reset)
      (accept && emit) |=> (rsp_valid_ff && edge_count_ff == 4'd0))
      else $error("completed frame not loaded into output register");

   // A byte taken in the third slot flags a packet
   assert property (@(posedge clock) disable iff (reset)
      (accept && emit && reporting_enable_ff && slot_index_ff == ps2fr_pkg::SLOT_THIRD)
      |=> rsp_payload_ff.packet_ready)
      else $error("third slot byte did not flag a packet");

   // A shown packet leaves the slot counter back at the first slot
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_payload_ff.packet_ready) |-> (slot_index_ff == ps2fr_pkg::SLOT_FIRST))
      else $error("slot counter not rewound after packet");

   // The sampler is never blocked by a sample that produces no result
   assert property (@(posedge clock) disable iff (reset)
      !emit |-> req_ready)
      else $error("sample without result stalled");

endmodule

// ===== verif/ps2_frame_receiver_packet_assembler_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the PS/2 frame receiver and packet assembler.
// Depends on ps2fr_pkg and on the ps2_frame_receiver_packet_assembler RTL.
module ps2_frame_receiver_packet_assembler_tb;

   // Clock, reset and block ports; every input starts at a known value
   logic               clock            = 1'b0;
   logic               reset            = 1'b1;
   logic               req_valid        = 1'b0;
   logic               req_ready;
   ps2fr_pkg::req_type req_payload      = '0;
   logic               rsp_valid;
   logic               rsp_ready        = 1'b0;
   ps2fr_pkg::rsp_type rsp_payload;
   logic               csr_write_enable = 1'b0;
   logic               csr_write_data   = 1'b0;

   // Idling controls, in percent of cycles
   int send_idle_pct    = 0;
   int recv_stall_pct   = 0;
   // Long receiver hold-off, counted down by the receiver process
   int long_hold_cycles = 0;

   int items_sent  = 0;
   int error_count = 0;

   // Predictor state, at its reset values
   logic       prev_clk_level = 1'b1;
   logic [3:0] frame_edges    = ps2fr_pkg::START_EDGE;
   logic [7:0] data_shift     = '0;
   logic       parity_capture = 1'b0;
   logic [1:0] slot_ptr       = ps2fr_pkg::SLOT_SKIP;
   logic [7:0] packet_bytes [2];
   logic       reporting_on   = 1'b0;

   // Frames predicted but not yet seen at the output, oldest first
   ps2fr_pkg::rsp_type awaited_frames [$];

   ps2_frame_receiver_packet_assembler u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #10 clock = ~clock;

   // Advance the predictor by one line sample; queue a frame when one completes.
   // A frame ends on the first rising clock edge after the eleventh falling edge.
   function automatic void decode_line_sample(input ps2fr_pkg::req_type sample);
      ps2fr_pkg::rsp_type done;
      logic               fall;
      logic               rise;
      fall = prev_clk_level && !sample.clk_line;
      rise = !prev_clk_level && sample.clk_line;
      prev_clk_level = sample.clk_line;
      if (fall) begin
         if (frame_edges >= ps2fr_pkg::FRAME_EDGES) begin
            frame_edges = ps2fr_pkg::START_EDGE;
         end else begin
            // start edge clears the byte; data bits arrive LSB first
            if (frame_edges == ps2fr_pkg::START_EDGE) begin
               data_shift = '0;
            end else if (frame_edges <= ps2fr_pkg::LAST_DATA_EDGE) begin
               data_shift = data_shift | (8'(sample.data_line) << (frame_edges - 4'd1));
            end else if (frame_edges == ps2fr_pkg::PARITY_EDGE) begin
               parity_capture = sample.data_line;
            end
            frame_edges = frame_edges + 4'd1;
         end
      end else if (rise && frame_edges == ps2fr_pkg::FRAME_EDGES) begin
         done = '0;
         frame_edges = ps2fr_pkg::START_EDGE;
         // with reporting off the slot pointer and held bytes stay put
         if (reporting_on) begin
            case (slot_ptr)
               ps2fr_pkg::SLOT_FIRST: begin
                  packet_bytes[0] = data_shift;
                  slot_ptr = ps2fr_pkg::SLOT_SECOND;
               end
               ps2fr_pkg::SLOT_SECOND: begin
                  packet_bytes[1] = data_shift;
                  slot_ptr = ps2fr_pkg::SLOT_THIRD;
               end
               ps2fr_pkg::SLOT_THIRD: begin
                  done.packet_ready  = 1'b1;
                  done.packet_first  = packet_bytes[0];
                  done.packet_second = packet_bytes[1];
                  done.packet_third  = data_shift;
                  slot_ptr = ps2fr_pkg::SLOT_FIRST;
               end
               default: begin
                  // skip slot: drop this byte from the packet
                  slot_ptr = ps2fr_pkg::SLOT_FIRST;
               end
            endcase
         end
         done.received_byte = data_shift;
         done.parity_bit    = parity_capture;
         awaited_frames.push_back(done);
      end else if (rise && frame_edges > ps2fr_pkg::FRAME_EDGES) begin
         frame_edges = ps2fr_pkg::START_EDGE;
      end
   endfunction

   // Report one field mismatch; keep the log bounded
   task automatic report_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
      if (got !== want) begin
         if (error_count < 60)
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
         error_count++;
      end
   endtask

   // Compare every accepted frame with the oldest prediction
   always @(posedge clock) begin
      ps2fr_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (awaited_frames.size() == 0) begin
            if (error_count < 60)
               $display("%0t: unexpected frame, expected none, actual %p", $time, rsp_payload);
            error_count++;
         end else begin
            want = awaited_frames.pop_front();
            report_field("received_byte", want.received_byte, rsp_payload.received_byte);
            report_field("parity_bit", 8'(want.parity_bit), 8'(rsp_payload.parity_bit));
            report_field("packet_ready", 8'(want.packet_ready), 8'(rsp_payload.packet_ready));
            report_field("packet_first", want.packet_first, rsp_payload.packet_first);
            report_field("packet_second", want.packet_second, rsp_payload.packet_second);
            report_field("packet_third", want.packet_third, rsp_payload.packet_third);
         end
      end
   end

   // Receiver: stall at random, or hold off completely during a long hold
   always @(negedge clock) begin
      if (long_hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         long_hold_cycles--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Offer one line sample, hold it until accepted, then predict it.
   // Call at a falling edge; returns at the falling edge after acceptance.
   task automatic send_sample(input logic clk_level, input logic data_level);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{clk_line: clk_level, data_line: data_level};
      do @(posedge clock); while (req_ready !== 1'b1);
      decode_line_sample(req_payload);
      items_sent++;
      @(negedge clock);
   endtask

   function automatic int phase_len(input bit brisk);
      if (brisk || $urandom_range(3) != 0)
         return 1;
      return $urandom_range(2, 4);
   endfunction

   // Drive a frame as line samples: each bit is a high then a low clock phase.
   // An edge_total short of a full frame leaves a broken frame behind.
   task automatic send_frame(input logic [7:0] data_byte, input logic par,
                             input logic start_bit, input logic stop_bit,
                             input int edge_total, input bit brisk);
      logic [10:0] frame_bits;
      frame_bits = {stop_bit, par, data_byte, start_bit};
      for (int i = 0; i < edge_total; i++) begin
         repeat (phase_len(brisk)) send_sample(1'b1, frame_bits[i]);
         repeat (phase_len(brisk)) send_sample(1'b0, frame_bits[i]);
      end
      // rising edge that closes a full frame
      if (edge_total == 11)
         send_sample(1'b1, 1'($urandom_range(1)));
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(5))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // Mostly well-formed frames with random content, plus noise and broken frames
   task automatic run_traffic(input int item_total, input int noise_pct);
      int stop_at;
      int pick;
      stop_at = items_sent + item_total;
      while (items_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < noise_pct) begin
            repeat ($urandom_range(1, 8))
               send_sample(1'($urandom_range(1)), 1'($urandom_range(1)));
         end else if (pick < 2 * noise_pct) begin
            send_frame(pick_byte(), 1'($urandom_range(1)), 1'($urandom_range(1)),
                       1'($urandom_range(1)), $urandom_range(1, 10), 1'b0);
         end else begin
            send_frame(pick_byte(), 1'($urandom_range(1)), 1'($urandom_range(1)),
                       1'($urandom_range(1)), 11, 1'b0);
         end
      end
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   // Drop valid, wait until every predicted frame is out, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      while (awaited_frames.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   // Write the reporting register while the block is idle
   task automatic write_reporting(input logic enable);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= enable;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      reporting_on = enable;
   endtask

   // Directed: one fast frame with all-ones data, parity one, odd start and stop
   task automatic test_line_extremes();
      set_idling(0, 0);
      send_frame(8'hFF, 1'b1, 1'b1, 1'b0, 11, 1'b1);
      drain();
   endtask

   // Bytes still come out with reporting off, never as packets
   task automatic test_frames_reporting_off();
      write_reporting(1'b0);
      set_idling(0, 0);
      run_traffic(300, 0);
   endtask

   // Enable reporting: first byte skipped, then packets of three, under all idling mixes
   task automatic test_packet_assembly();
      write_reporting(1'b1);
      set_idling(0, 0);
      run_traffic(100, 0);
      set_idling(45, 0);
      run_traffic(250, 3);
      set_idling(0, 45);
      run_traffic(250, 3);
      set_idling(19, 19);
      run_traffic(250, 3);
   endtask

   // Toggle reporting mid-packet; the slot pointer must not move
   task automatic test_reporting_toggle();
      write_reporting(1'b0);
      set_idling(19, 19);
      run_traffic(150, 0);
      write_reporting(1'b1);
      run_traffic(150, 0);
   endtask

   // Heavy noise and truncated frames knock the edge counter out of step
   task automatic test_line_noise();
      set_idling(19, 19);
      run_traffic(250, 20);
   endtask

   // Hold the receiver off so the output backs up and the input stalls
   task automatic test_output_backpressure();
      drain();
      set_idling(0, 0);
      long_hold_cycles = 400;
      run_traffic(150, 0);
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_line_extremes();
      test_frames_reporting_off();
      test_packet_assembly();
      test_reporting_toggle();
      test_line_noise();
      test_output_backpressure();
      drain();
      repeat (5) @(negedge clock);
      if (error_count == 0)
         $display("[ps2_frame_receiver_packet_assembler] OK");
      else
         $display("[ps2_frame_receiver_packet_assembler] ERROR");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run
   initial begin
      #4000000;
      $display("%0t: timeout", $time);
      $display("[ps2_frame_receiver_packet_assembler] ERROR");
      $finish;
   end

endmodule
